>>> design/sis_pkg.sv
// Shared types and codes for the stable insertion sorter.
// No dependencies; imported by sis_cell, stable_insertion_sorter and both bench files.
package sis_pkg;

    // Configuration register indexes
    localparam logic REG_DESCENDING = 1'b0;
    localparam logic REG_SIGNED_KEYS = 1'b1;

    // Field widths fixed by the stream interface
    localparam int KEY_FIELD_BITS = 32;
    localparam int TAG_FIELD_BITS = 16;
    // Widest key and tag the cells may be built with
    localparam int KEY_EXT_BITS = 64;
    localparam int TAG_EXT_BITS = 32;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } sort_state_t;

    // Broadcast control shared by every cell of the chain
    typedef struct packed {
        logic insert;      // place the incoming record this cycle
        logic drain;       // shift the whole chain one cell toward the head
        logic descending;  // largest key first
        logic signed_keys; // compare keys as two's complement
    } cell_ctrl_t;

endpackage

>>> design/stable_insertion_sorter.sv
// Stable insertion sorter: a chain of MAX_ITEMS cells holds the sorted list.
// A record is placed in the cell chain in the cycle after its beat; after the
// tlast beat the state turns to drain and cell 0 then feeds the output register.
// Throughput: 1 record per cycle while loading; the n records of a set drain
// at 1 result per cycle via cell 0 unless m_tready stalls; no input in drain.
// Reset clears the record count, overflow flag, state, output valid and config.
module stable_insertion_sorter #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    // input records
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] sort_key, [47:32] record_tag
    input  logic        s_tlast,   // last_item
    // sorted results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] sorted_key, [47:32] sorted_tag
    output logic        m_tlast,   // final_result
    output logic [0:0]  m_tuser    // [0] overflow
);
    import sis_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    sort_state_t      state_reg;
    sort_state_t      state_next;
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;
    logic [CNT_W-1:0] drain_left_reg;
    logic [CNT_W-1:0] drain_left_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             descending_reg;
    logic             signed_keys_reg;

    logic             out_valid_reg;
    logic [KEY_FIELD_BITS-1:0] out_key_reg;
    logic [TAG_FIELD_BITS-1:0] out_tag_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    logic             in_fire;
    logic             full;
    logic             load_out;
    cell_ctrl_t       ctrl;

    logic [KEY_EXT_BITS-1:0] in_key_ext;
    logic [TAG_EXT_BITS-1:0] in_tag_ext;
    logic [KEY_BITS-1:0]     in_key;
    logic [TAG_BITS-1:0]     in_tag;
    logic [KEY_EXT_BITS-1:0] head_key_ext;
    logic [TAG_EXT_BITS-1:0] head_tag_ext;

    logic [KEY_BITS-1:0] cell_key [MAX_ITEMS];
    logic [TAG_BITS-1:0] cell_tag [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] blk;
    logic [MAX_ITEMS-1:0] sfx;
    logic [MAX_ITEMS-1:0] after;

    // ---- input fields ----
    assign in_key_ext = {{(KEY_EXT_BITS-KEY_FIELD_BITS){1'b0}}, s_tdata[31:0]};
    assign in_tag_ext = {{(TAG_EXT_BITS-TAG_FIELD_BITS){1'b0}}, s_tdata[47:32]};
    assign in_key     = in_key_ext[KEY_BITS-1:0];
    assign in_tag     = in_tag_ext[TAG_BITS-1:0];

    assign s_tready = (state_reg == ST_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign full     = (fill_count_reg == CNT_MAX);
    assign load_out = (state_reg == ST_DRAIN) && (drain_left_reg != '0)
                      && (!out_valid_reg || m_tready);

    assign ctrl.insert      = in_fire && !full;
    assign ctrl.drain       = load_out;
    assign ctrl.descending  = descending_reg;
    assign ctrl.signed_keys = signed_keys_reg;

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg  <= 1'b0;
            signed_keys_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DESCENDING:  descending_reg  <= cfg_data;
                REG_SIGNED_KEYS: signed_keys_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- cell chain ----
    // Suffix OR of the blocking flags, log-depth: a cell with no blocker at or
    // beyond it lies at or past the insertion point.
    always_comb
    begin
        sfx = blk;
        for (int d = 1; d < MAX_ITEMS; d = d * 2)
        begin
            for (int i = 0; i < MAX_ITEMS; i++)
            begin
                if (i + d < MAX_ITEMS)
                begin
                    sfx[i] = sfx[i] | sfx[i + d];
                end
            end
        end
        after = ~sfx;
    end

    for (genvar g = 0; g < MAX_ITEMS; g++)
    begin : g_cell
        logic occupied;
        logic after_left;
        logic [KEY_BITS-1:0] lk;
        logic [TAG_BITS-1:0] lt;
        logic [KEY_BITS-1:0] rk;
        logic [TAG_BITS-1:0] rt;

        assign occupied = (CNT_W'(g) < fill_count_reg);

        if (g == 0)
        begin : g_head
            assign after_left = 1'b0;
            assign lk = in_key;
            assign lt = in_tag;
        end
        else
        begin : g_body
            assign after_left = after[g-1];
            assign lk = cell_key[g-1];
            assign lt = cell_tag[g-1];
        end

        if (g == MAX_ITEMS - 1)
        begin : g_tail
            assign rk = cell_key[g];
            assign rt = cell_tag[g];
        end
        else
        begin : g_inner
            assign rk = cell_key[g+1];
            assign rt = cell_tag[g+1];
        end

        sis_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .after_self (after[g]),
            .after_left (after_left),
            .new_key    (in_key),
            .new_tag    (in_tag),
            .left_key   (lk),
            .left_tag   (lt),
            .right_key  (rk),
            .right_tag  (rt),
            .key        (cell_key[g]),
            .tag        (cell_tag[g]),
            .blocks     (blk[g])
        );
    end

    // ---- control ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            fill_count_reg <= '0;
            drain_left_reg <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            drain_left_reg <= drain_left_next;
            dropped_reg    <= dropped_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        drain_left_next = drain_left_reg;
        dropped_next    = dropped_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        fill_count_next = fill_count_reg + CNT_ONE;
                    end
                    if (s_tlast)
                    begin
                        state_next      = ST_DRAIN;
                        drain_left_next = full ? fill_count_reg : fill_count_reg + CNT_ONE;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load_out)
                begin
                    drain_left_next = drain_left_reg - CNT_ONE;
                    if (drain_left_reg == CNT_ONE)
                    begin
                        // last result leaves: clear the list for the next set
                        state_next      = ST_LOAD;
                        fill_count_next = '0;
                        dropped_next    = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // ---- output register ----
    assign head_key_ext = {{(KEY_EXT_BITS-KEY_BITS){1'b0}}, cell_key[0]};
    assign head_tag_ext = {{(TAG_EXT_BITS-TAG_BITS){1'b0}}, cell_tag[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_key_reg  <= head_key_ext[KEY_FIELD_BITS-1:0];
            out_tag_reg  <= head_tag_ext[TAG_FIELD_BITS-1:0];
            out_last_reg <= (drain_left_reg == CNT_ONE);
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_tag_reg, out_key_reg};
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_ovf_reg;

    // ---- assertions ----
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_MAX)
        else $error("record count exceeds capacity");

    a_drain_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> (drain_left_reg <= fill_count_reg && drain_left_reg != '0))
        else $error("drain count out of range");

    a_fill_holds_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |=> (state_reg == ST_LOAD || $stable(fill_count_reg)))
        else $error("record count moved during drain");

    a_final_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && drain_left_reg == CNT_ONE)
        |=> (state_reg == ST_LOAD && fill_count_reg == '0 && !dropped_reg && m_tlast))
        else $error("final result did not close the set");

endmodule

>>> design/sis_cell.sv
// One storage cell of the insertion chain: holds a key and a tag, compares
// the incoming key with its own and loads a neighbor or the new record when told.
// Depends on sis_pkg.
module sis_cell #(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  logic                  clk,
    input  sis_pkg::cell_ctrl_t   ctrl,
    input  logic                  occupied,
    input  logic                  after_self,
    input  logic                  after_left,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [TAG_BITS-1:0]   new_tag,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [TAG_BITS-1:0]   left_tag,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [TAG_BITS-1:0]   right_tag,
    output logic [KEY_BITS-1:0]   key,
    output logic [TAG_BITS-1:0]   tag,
    output logic                  blocks
);
    import sis_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;
    logic [KEY_BITS-1:0] flip;
    logic [KEY_BITS-1:0] rank_new;
    logic [KEY_BITS-1:0] rank_own;
    logic                goes_before;

    // Flip the sign bit so that signed keys order as unsigned ranks
    assign flip     = {ctrl.signed_keys, {(KEY_BITS-1){1'b0}}};
    assign rank_new = new_key ^ flip;
    assign rank_own = key_reg ^ flip;
    assign goes_before = ctrl.descending ? (rank_new > rank_own) : (rank_new < rank_own);

    // An occupied cell the new record may not pass stops its leftward move
    assign blocks = occupied && !goes_before;

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.drain)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
        else if (ctrl.insert && after_self)
        begin
            if (after_left)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else
            begin
                key_next = new_key;
                tag_next = new_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

>>> bench/sis_sort_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the stable insertion sorter: tracks config writes, keeps its
// own sorted record list and checks every result beat. Depends on sis_pkg.
module sis_sort_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] sort_key, [47:32] record_tag
    input  logic        s_tlast,   // last_item
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [31:0] sorted_key, [47:32] sorted_tag
    input  logic        m_tlast,   // final_result
    input  logic [0:0]  m_tuser,   // [0] overflow
    output int          fail_count,
    output int          pending
);
    import sis_pkg::*;

    typedef struct packed {
        logic [KEY_FIELD_BITS-1:0] key;
        logic [TAG_FIELD_BITS-1:0] tag;
        logic                      last;
        logic                      ovf;
    } sorted_rec_t;

    logic [KEY_FIELD_BITS-1:0] held_key [CAPACITY];
    logic [TAG_FIELD_BITS-1:0] held_tag [CAPACITY];
    int          held_count = 0;
    logic        held_dropped = 1'b0;
    logic        order_desc = 1'b0;
    logic        keys_signed = 1'b0;
    sorted_rec_t sorted_q [$];
    sorted_rec_t exp_rec;
    sorted_rec_t got_rec;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // True when key a has to sit strictly ahead of key b.
    function automatic logic ranks_ahead(input logic [KEY_FIELD_BITS-1:0] a,
                                         input logic [KEY_FIELD_BITS-1:0] b);
        logic [KEY_FIELD_BITS-1:0] ra;
        logic [KEY_FIELD_BITS-1:0] rb;
        // flip the sign bit so two's complement orders as unsigned
        ra = keys_signed ? {~a[KEY_FIELD_BITS-1], a[KEY_FIELD_BITS-2:0]} : a;
        rb = keys_signed ? {~b[KEY_FIELD_BITS-1], b[KEY_FIELD_BITS-2:0]} : b;
        return order_desc ? (ra > rb) : (ra < rb);
    endfunction

    task automatic place_record(input logic [KEY_FIELD_BITS-1:0] key,
                                input logic [TAG_FIELD_BITS-1:0] tag);
        int pos;
        if (held_count >= CAPACITY)
        begin
            held_dropped = 1'b1;
            return;
        end
        pos = held_count;
        // walk back past every record that ranks behind; ties stay in front
        while (pos > 0 && ranks_ahead(key, held_key[pos-1]))
        begin
            held_key[pos] = held_key[pos-1];
            held_tag[pos] = held_tag[pos-1];
            pos--;
        end
        held_key[pos] = key;
        held_tag[pos] = tag;
        held_count++;
    endtask

    task automatic release_list();
        sorted_rec_t rec;
        for (int i = 0; i < held_count; i++)
        begin
            rec.key  = held_key[i];
            rec.tag  = held_tag[i];
            rec.last = (i == held_count - 1);
            rec.ovf  = held_dropped;
            sorted_q.push_back(rec);
        end
        held_count = 0;
        held_dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            held_dropped = 1'b0;
            order_desc = 1'b0;
            keys_signed = 1'b0;
            sorted_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DESCENDING)
                    order_desc = cfg_data;
                else if (cfg_index == REG_SIGNED_KEYS)
                    keys_signed = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got_rec.key  = m_tdata[31:0];
                got_rec.tag  = m_tdata[47:32];
                got_rec.last = m_tlast;
                got_rec.ovf  = m_tuser[0];
                if (sorted_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, %s %h %h %b %b",
                             $time, "actual key/tag/last/ovf", got_rec.key, got_rec.tag,
                             got_rec.last, got_rec.ovf);
                end
                else
                begin
                    exp_rec = sorted_q.pop_front();
                    if (got_rec.key !== exp_rec.key || got_rec.tag !== exp_rec.tag ||
                        got_rec.last !== exp_rec.last || got_rec.ovf !== exp_rec.ovf)
                    begin
                        fail_count++;
                        $display("%0t: result mismatch, expected key %h tag %h last %b ovf %b",
                                 $time, exp_rec.key, exp_rec.tag, exp_rec.last, exp_rec.ovf);
                        $display("%0t:   actual key %h tag %h last %b ovf %b",
                                 $time, got_rec.key, got_rec.tag, got_rec.last, got_rec.ovf);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                place_record(s_tdata[31:0], s_tdata[47:32]);
                if (s_tlast)
                    release_list();
            end
        end
        pending = sorted_q.size();
    end

endmodule

>>> bench/tb_stable_insertion_sorter.sv
`timescale 1ns / 1ps
// Top of the sorter bench: clock, reset, record sets and result back-pressure.
// Depends on sis_pkg, stable_insertion_sorter and sis_sort_checker.
module tb_stable_insertion_sorter;
    import sis_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // [31:0] sort_key, [47:32] record_tag
    logic        s_tlast = 1'b0; // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // [31:0] sorted_key, [47:32] sorted_tag
    logic        m_tlast;        // final_result
    logic [0:0]  m_tuser;        // [0] overflow

    int fail_count;
    int pending;
    int sink_pct = 0;
    int sink_hold = 0;

    stable_insertion_sorter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    sis_sort_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: drop m_tready in random stall bursts, as often as sink_pct sets.
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end
        else if (sink_pct > 0 && $urandom_range(0, 99) < sink_pct)
        begin
            sink_hold <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Keys biased toward ties and the ends of both number ranges.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3);
            1: return 32'h7FFF_FFFE + $urandom_range(0, 3);
            2: return 32'hFFFF_FFFD + $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    // Drop valid, then hold until every expected result is out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(input logic desc, input logic sgn);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= REG_DESCENDING;
        cfg_data <= desc;
        @(posedge clk);
        cfg_index <= REG_SIGNED_KEYS;
        cfg_data <= sgn;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_record(input logic [31:0] key, input logic [15:0] tag,
                               input logic last, input int gap_pct);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tdata <= {tag, key};
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int rand_items;
        int set_no;
        int set_len;
        int gap_pct;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ascending unsigned: extremes, ties in arrival order, tag extremes
        send_record(32'd5, 16'h0001, 1'b0, 0);
        send_record(32'h0000_0000, 16'h0002, 1'b0, 0);
        send_record(32'hFFFF_FFFF, 16'h0003, 1'b0, 0);
        send_record(32'h8000_0000, 16'h0004, 1'b0, 0);
        send_record(32'd5, 16'h0005, 1'b0, 0);
        send_record(32'h7FFF_FFFF, 16'h0006, 1'b0, 0);
        send_record(32'd5, 16'hFFFF, 1'b0, 0);
        send_record(32'h0000_0000, 16'h0000, 1'b1, 0);
        // lone record
        send_record(32'h1234_5678, 16'hA5A5, 1'b1, 0);

        set_mode(1'b1, 1'b1);
        sink_pct <= 30;
        send_record(32'h8000_0000, 16'h0010, 1'b0, 30);
        send_record(32'h7FFF_FFFF, 16'h0011, 1'b0, 30);
        send_record(32'hFFFF_FFFF, 16'h0012, 1'b0, 30);
        send_record(32'h0000_0000, 16'h0013, 1'b0, 30);
        send_record(32'h8000_0000, 16'h0014, 1'b0, 30);
        send_record(32'h0000_0001, 16'h0015, 1'b1, 30);

        set_mode(1'b0, 1'b1);
        send_record(32'hFFFF_FFFF, 16'h0020, 1'b0, 0);
        send_record(32'h0000_0000, 16'h0021, 1'b0, 0);
        send_record(32'h8000_0000, 16'h0022, 1'b0, 0);
        send_record(32'h7FFF_FFFF, 16'h0023, 1'b1, 0);

        set_mode(1'b1, 1'b0);
        send_record(32'h0000_0000, 16'h0030, 1'b0, 0);
        send_record(32'hFFFF_FFFF, 16'h0031, 1'b0, 0);
        send_record(32'h8000_0000, 16'h0032, 1'b1, 0);

        rand_items = 0;
        set_no = 0;
        while (rand_items < 160)
        begin
            if (rand_items >= 130)
            begin
                gap_pct = 0;
                sink_pct <= 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        gap_pct = 0;
                        sink_pct <= 0;
                    end
                    1:
                    begin
                        gap_pct = 20;
                        sink_pct <= 15;
                    end
                    default:
                    begin
                        gap_pct = 50;
                        sink_pct <= 40;
                    end
                endcase
            end
            // one set fills the list exactly, a later one runs past it
            if (set_no == 2)
                set_len = 64;
            else if (set_no == 5)
                set_len = 67;
            else
                set_len = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
                set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (int i = 0; i < set_len; i++)
                send_record(pick_key(), 16'($urandom_range(0, 65535)),
                            i == set_len - 1, gap_pct);
            rand_items += set_len;
            set_no++;
        end

        wait_idle();
        repeat (6) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
